// ===== rtl/cslc_pkg.sv =====
// shared types, constants and helper functions of the c source lexical classifier
package cslc_pkg;

    localparam int MAX_RUN = 512;
    localparam int CNT_W   = $clog2(MAX_RUN + 1);
    localparam int LEN_W   = 10;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [7:0] CH_SLASH  = 8'd47;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_UNDER  = 8'd95;

    typedef enum logic [2:0] {
        CL_OPER  = 3'd0,
        CL_BLANK = 3'd1,
        CL_IDENT = 3'd2,
        CL_LCOM  = 3'd3,
        CL_BCOM  = 3'd4,
        CL_DQ    = 3'd5,
        CL_SQ    = 3'd6,
        CL_ERR   = 3'd7
    } class_t;

    typedef enum logic [10:0] {
        ST_START = 11'b000_0000_0001,
        ST_SLASH = 11'b000_0000_0010,
        ST_LCOM  = 11'b000_0000_0100,
        ST_BCOM  = 11'b000_0000_1000,
        ST_BSTAR = 11'b000_0001_0000,
        ST_DQ    = 11'b000_0010_0000,
        ST_SQ    = 11'b000_0100_0000,
        ST_BLANK = 11'b000_1000_0000,
        ST_IDENT = 11'b001_0000_0000,
        ST_DQESC = 11'b010_0000_0000,
        ST_SQESC = 11'b100_0000_0000
    } state_t;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        cnt_t cnt;
        logic ovf;
    } pend_t;

    typedef struct packed {
        class_t          cls;
        logic [LEN_W-1:0] len;
        logic            sat;
    } res_t;

    // one queue entry: the labels caused by one byte
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t data;
    } q_wr_t;

    typedef struct packed {
        logic   vld;
        entry_t data;
    } q_rd_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122) ||
               (c >= 8'd48 && c <= 8'd57) || (c == CH_UNDER);
    endfunction

    function automatic pend_t push_char(input pend_t p);
        pend_t r;
        r = p;
        if (p.cnt < CNT_W'(MAX_RUN))
            r.cnt = p.cnt + 1'b1;
        else
            r.ovf = 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/cslc_char_if.sv =====
// input channel: one source byte per word
interface cslc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

// ===== rtl/cslc_token_if.sv =====
// output channel: one (class, run length) label per word
interface cslc_token_if;
    logic       valid;
    logic       ready;
    logic [2:0] token_class;
    logic [9:0] run_length;
    logic       run_saturated;
    logic       last_of_item;

    modport source (output valid, output token_class, output run_length,
                    output run_saturated, output last_of_item, input ready);
    modport sink   (input valid, input token_class, input run_length,
                    input run_saturated, input last_of_item, output ready);
endinterface

// ===== rtl/cslc_front.sv =====
// scanner front end: takes bytes, runs the state machine, queues labels
module cslc_front (
    input  logic              clk,
    input  logic              rst_n,
    cslc_char_if.sink         char_in,
    input  logic              q_full,
    output cslc_pkg::q_wr_t   q_wr
);
    import cslc_pkg::*;

    state_t     st_reg, st_next;
    pend_t      pend_reg, pend_next;
    logic       accept;
    logic [7:0] c;

    assign c             = char_in.char_code;
    assign char_in.ready = !q_full;
    assign accept        = char_in.valid && char_in.ready;

    always_comb
    begin
        pend_t    p;
        logic     pre_push;
        logic     do_flush;
        logic     take;
        class_t   fl_cls;
        logic [1:0] n;
        res_t     r0;
        res_t     r1;
        res_t     e;

        p        = pend_reg;
        st_next  = st_reg;
        pre_push = 1'b0;
        do_flush = 1'b0;
        take     = 1'b0;
        fl_cls   = CL_OPER;
        n        = 2'd0;
        r0       = '0;
        r1       = '0;
        e        = '0;

        unique case (st_reg) inside
            ST_SLASH:
            begin
                if (c == CH_SLASH)
                begin
                    pre_push = 1'b1;
                    st_next  = ST_LCOM;
                end
                else if (c == CH_STAR)
                begin
                    pre_push = 1'b1;
                    st_next  = ST_BCOM;
                end
                else
                begin
                    do_flush = 1'b1;
                    fl_cls   = CL_OPER;
                    take     = 1'b1;
                end
            end
            ST_LCOM:
            begin
                if (c == CH_LF)
                begin
                    do_flush = 1'b1;
                    fl_cls   = CL_LCOM;
                    st_next  = ST_START;
                end
                else
                    pre_push = 1'b1;
            end
            ST_BCOM:
            begin
                if (c == CH_STAR)
                begin
                    pre_push = 1'b1;
                    st_next  = ST_BSTAR;
                end
                else if (c == CH_LF)
                begin
                    do_flush = 1'b1;
                    fl_cls   = CL_BCOM;
                end
                else
                    pre_push = 1'b1;
            end
            ST_BSTAR:
            begin
                if (c == CH_STAR)
                    pre_push = 1'b1;
                else if (c == CH_SLASH)
                begin
                    pre_push = 1'b1;
                    do_flush = 1'b1;
                    fl_cls   = CL_BCOM;
                    st_next  = ST_START;
                end
                else if (c == CH_LF)
                begin
                    do_flush = 1'b1;
                    fl_cls   = CL_BCOM;
                    st_next  = ST_BCOM;
                end
                else
                begin
                    pre_push = 1'b1;
                    st_next  = ST_BCOM;
                end
            end
            ST_DQ, ST_SQ:
            begin
                if (c == ((st_reg == ST_DQ) ? CH_DQUOTE : CH_SQUOTE))
                begin
                    pre_push = 1'b1;
                    do_flush = 1'b1;
                    fl_cls   = (st_reg == ST_DQ) ? CL_DQ : CL_SQ;
                    st_next  = ST_START;
                end
                else if (c == CH_LF)
                begin
                    do_flush = 1'b1;
                    fl_cls   = CL_ERR;
                    st_next  = ST_START;
                end
                else if (c == CH_BSLASH)
                begin
                    pre_push = 1'b1;
                    st_next  = (st_reg == ST_DQ) ? ST_DQESC : ST_SQESC;
                end
                else
                    pre_push = 1'b1;
            end
            ST_DQESC, ST_SQESC:
            begin
                if (c == CH_LF)
                begin
                    do_flush = 1'b1;
                    fl_cls   = CL_ERR;
                    st_next  = ST_START;
                end
                else
                begin
                    pre_push = 1'b1;
                    st_next  = (st_reg == ST_DQESC) ? ST_DQ : ST_SQ;
                end
            end
            ST_BLANK:
            begin
                if (is_blank(c))
                    pre_push = 1'b1;
                else
                begin
                    do_flush = 1'b1;
                    fl_cls   = CL_BLANK;
                    take     = 1'b1;
                end
            end
            ST_IDENT:
            begin
                if (is_word(c))
                    pre_push = 1'b1;
                else
                begin
                    do_flush = 1'b1;
                    fl_cls   = CL_IDENT;
                    take     = 1'b1;
                end
            end
            default:
                take = 1'b1;
        endcase

        if (pre_push)
            p = push_char(p);

        if (do_flush)
        begin
            if (p.cnt != '0)
            begin
                r0.cls = fl_cls;
                r0.len = LEN_W'(p.cnt);
                r0.sat = p.ovf;
                n      = 2'd1;
            end
            p = '0;
        end

        // byte taken as in start state after the run closed
        if (take)
        begin
            st_next = ST_START;
            if (c == CH_SLASH)
            begin
                p       = push_char(p);
                st_next = ST_SLASH;
            end
            else if (c == CH_DQUOTE)
            begin
                p       = push_char(p);
                st_next = ST_DQ;
            end
            else if (c == CH_SQUOTE)
            begin
                p       = push_char(p);
                st_next = ST_SQ;
            end
            else if (c == CH_LF)
            begin
                p = p;
            end
            else if (is_blank(c))
            begin
                p       = push_char(p);
                st_next = ST_BLANK;
            end
            else if (is_word(c))
            begin
                p       = push_char(p);
                st_next = ST_IDENT;
            end
            else
            begin
                e.cls = CL_OPER;
                e.len = LEN_W'(1);
                e.sat = 1'b0;
                if (n == 2'd0)
                    r0 = e;
                else
                    r1 = e;
                n = n + 2'd1;
            end
        end

        pend_next       = p;
        q_wr.push       = accept && (n != 2'd0);
        q_wr.data.two   = (n == 2'd2);
        q_wr.data.r0    = r0;
        q_wr.data.r1    = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_START;
            pend_reg <= '0;
        end
        else if (accept)
        begin
            st_reg   <= st_next;
            pend_reg <= pend_next;
        end
    end

endmodule

// ===== rtl/cslc_queue.sv =====
// small register queue between scanner and output stage
module cslc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  cslc_pkg::q_wr_t   q_wr,
    output logic              q_full,
    input  logic              q_pop,
    output cslc_pkg::q_rd_t   q_rd
);
    import cslc_pkg::*;

    entry_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   cnt_reg;
    logic            do_pop;

    assign q_full    = (cnt_reg == (Q_AW + 1)'(Q_DEPTH));
    assign q_rd.vld  = (cnt_reg != '0);
    assign q_rd.data = mem_reg[rd_ptr_reg];
    assign do_pop    = q_pop && q_rd.vld;

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
            mem_reg[wr_ptr_reg] <= q_wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (q_wr.push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (q_wr.push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!q_wr.push && do_pop)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/cslc_back.sv =====
// output stage: holds one queue entry and sends its labels one word at a time
module cslc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  cslc_pkg::q_rd_t   q_rd,
    output logic              q_pop,
    cslc_token_if.source      token_out
);
    import cslc_pkg::*;

    entry_t hold_reg;
    logic   hold_vld_reg;
    logic   phase_reg;
    logic   xfer;
    logic   done;
    res_t   cur;

    assign cur   = phase_reg ? hold_reg.r1 : hold_reg.r0;
    assign xfer  = hold_vld_reg && token_out.ready;
    assign done  = xfer && (phase_reg || !hold_reg.two);
    assign q_pop = q_rd.vld && (!hold_vld_reg || done);

    assign token_out.valid         = hold_vld_reg;
    assign token_out.token_class   = cur.cls;
    assign token_out.run_length    = cur.len;
    assign token_out.run_saturated = cur.sat;
    assign token_out.last_of_item  = hold_reg.two ? phase_reg : 1'b1;

    always_ff @(posedge clk)
    begin
        if (q_pop)
            hold_reg <= q_rd.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end
        else if (q_pop)
        begin
            hold_vld_reg <= 1'b1;
            phase_reg    <= 1'b0;
        end
        else if (done)
        begin
            hold_vld_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end
        else if (xfer)
            phase_reg <= 1'b1;
    end

endmodule

// ===== rtl/c_source_lexical_classifier_unit.sv =====
// top level of the c source lexical classifier
//
// char_in takes one source byte per word; byte 10 ends a line and counts
// as no character. token_out gives (class, run length) labels covering the
// oldest unlabeled characters in stream order, with last_of_item set on the
// final label a byte causes. A byte may cause zero, one or two labels.
// The scanner takes a byte every cycle while its four-entry label queue has
// room; with the output stage idle, a byte's first label is written into the
// queue and then loaded into the output stage's hold register, which offers
// it on token_out.
// The output stage sends one label per cycle while token_out is ready, so
// sustained rate is one byte per cycle, less only where a byte closes a
// run and also yields a label of its own and so needs two output words.
// When token_out stalls, labels wait in the output stage and the queue;
// char_in.ready drops only once the queue is full.
// Reset puts the scanner in its start state with nothing pending and
// empties the queue and output stage; there is no clearing pass.
module c_source_lexical_classifier_unit (
    input  logic         clk,
    input  logic         rst_n,
    cslc_char_if.sink    char_in,
    cslc_token_if.source token_out
);
    import cslc_pkg::*;

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  q_pop;

    cslc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .q_full  (q_full),
        .q_wr    (q_wr)
    );

    cslc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_pop  (q_pop),
        .q_rd   (q_rd)
    );

    cslc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd      (q_rd),
        .q_pop     (q_pop),
        .token_out (token_out)
    );

endmodule
